@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, also while reset is held.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check a property on every rising edge outside reset (reset active low).
`define ASSERT_RUN(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

@@ rtl/core/mhpc_pkg.sv @@
// Shared constants, types and state encodings of the pump control unit.
`timescale 1ns / 1ps

package mhpc_pkg;

    localparam int WINDOW_LEN = 10;
    localparam int IDX_W      = $clog2(WINDOW_LEN);
    localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
    localparam int MED_K      = WINDOW_LEN / 2;

    localparam int SAMPLE_W   = 18;
    localparam int WIN_W      = 19;
    localparam int OFFSET_W   = 12;
    localparam int POT_W      = 12;
    localparam int BAT_W      = 12;
    localparam int CBAR_W     = 8;
    localparam int HYST_W     = 16;
    localparam int TGT_W      = 18;
    localparam int PROD_W     = 20;
    localparam int CMP_W      = 21;
    localparam int BIT_CNT_W  = $clog2(POT_W);

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [PROD_W-1:0] PA_PER_CBAR = PROD_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BATT    = 3'd4;

    localparam logic [OFFSET_W-1:0] OFFSET_RST      = 12'd600;
    localparam logic [CBAR_W-1:0]   TARGET_MIN_RST  = 8'd10;
    localparam logic [CBAR_W-1:0]   TARGET_MAX_RST  = 8'd50;
    localparam logic [HYST_W-1:0]   HYSTERESIS_RST  = 16'd3000;
    localparam logic [BAT_W-1:0]    LOW_BATT_RST    = 12'd882;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_SPAN,
        ST_SCALE,
        ST_MUL_PA,
        ST_COMPARE,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MED_IDLE,
        MED_SCAN,
        MED_DRAIN
    } med_state_t;

    typedef struct packed {
        logic                    push;
        logic signed [WIN_W-1:0] value;
    } med_cmd_t;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [WIN_W-1:0] median;
    } med_stat_t;

endpackage

@@ rtl/core/median_hysteresis_pump_control_unit.sv @@
// Top level: sample intake, bit-serial target mapping and hysteresis pump control.
// Sample request: the request that completes a block of WINDOW_LEN
//   starts a median scan that ranks each window RAM entry against every entry.
// Adjust tick: the result comes from 12-bit and 8-bit shift-add steps, then the compare.
// No new request is taken during a median scan or a tick; a waiting result holds the next tick.
// Reset: config registers take their default values, pump off, median zero, window RAM kept.
`timescale 1ns / 1ps

module median_hysteresis_pump_control_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // sample_pa[17:0], sample_ok[18], pot_code[30:19], battery_code[42:31], zero[47:43]
    input  logic [mhpc_pkg::IN_TDATA_W-1:0]       s_tdata,
    // req_type[0]
    input  logic [0:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // pump_on[0], low_batt[1], control_updated[2], median_pa[21:3], target_pa[39:22]
    output logic [mhpc_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mhpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mhpc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    mhpc_pkg::ctrl_state_t state_reg, state_next;

    logic [mhpc_pkg::OFFSET_W-1:0]      offset_reg;
    logic [mhpc_pkg::CBAR_W-1:0]        target_min_reg;
    logic [mhpc_pkg::CBAR_W-1:0]        target_max_reg;
    logic [mhpc_pkg::HYST_W-1:0]        hysteresis_reg;
    logic [mhpc_pkg::BAT_W-1:0]         low_batt_thr_reg;

    logic signed [mhpc_pkg::WIN_W-1:0]  median_latched_reg;
    logic                               median_ready_reg;
    logic                               pump_reg;
    logic                               m_tvalid_reg;
    logic [mhpc_pkg::OUT_TDATA_W-1:0]   m_tdata_reg;

    logic [mhpc_pkg::PROD_W-1:0]        acc_reg;
    logic [mhpc_pkg::PROD_W-1:0]        mcand_reg;
    logic [mhpc_pkg::POT_W-1:0]         sr_reg;
    logic [mhpc_pkg::BIT_CNT_W-1:0]     bit_cnt_reg;
    logic                               span_neg_reg;
    logic                               bat_low_reg;
    logic                               updated_reg;
    logic [mhpc_pkg::TGT_W-1:0]         target_reg;

    logic                               in_tick;
    logic signed [mhpc_pkg::SAMPLE_W-1:0] in_sample;
    logic                               in_ok;
    logic [mhpc_pkg::POT_W-1:0]         in_pot;
    logic [mhpc_pkg::BAT_W-1:0]         in_bat;
    logic                               s_accept;
    logic                               out_load;
    logic                               ready_int;

    logic signed [mhpc_pkg::WIN_W-1:0]  sample_ext;
    logic signed [mhpc_pkg::WIN_W-1:0]  offset_ext;
    logic                               span_neg;
    logic [mhpc_pkg::CBAR_W-1:0]        span_mag;
    logic [mhpc_pkg::CBAR_W-1:0]        quot;
    logic [mhpc_pkg::CBAR_W-1:0]        cbar;
    logic signed [mhpc_pkg::CMP_W-1:0]  median_ext;
    logic signed [mhpc_pkg::CMP_W-1:0]  target_ext;
    logic signed [mhpc_pkg::CMP_W-1:0]  hyst_ext;
    logic signed [mhpc_pkg::CMP_W-1:0]  band_lo;
    logic signed [mhpc_pkg::CMP_W-1:0]  band_hi;

    mhpc_pkg::med_cmd_t  med_cmd;
    mhpc_pkg::med_stat_t med_stat;

    assign in_tick   = s_tuser[0];
    assign in_sample = $signed(s_tdata[17:0]);
    assign in_ok     = s_tdata[18];
    assign in_pot    = s_tdata[30:19];
    assign in_bat    = s_tdata[42:31];
    assign s_accept  = s_tvalid && ready_int;

    assign sample_ext    = mhpc_pkg::WIN_W'(in_sample);
    assign offset_ext    = $signed({{(mhpc_pkg::WIN_W - mhpc_pkg::OFFSET_W){1'b0}}, offset_reg});
    assign med_cmd.push  = s_accept && !in_tick && in_ok;
    assign med_cmd.value = sample_ext - offset_ext;

    mhpc_median u_median (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (med_cmd),
        .stat    (med_stat)
    );

    always_comb begin
        span_neg = (target_max_reg < target_min_reg);
        span_mag = span_neg ? (target_min_reg - target_max_reg)
                            : (target_max_reg - target_min_reg);
        quot     = acc_reg[mhpc_pkg::PROD_W-1:mhpc_pkg::POT_W];
        cbar     = span_neg_reg ? (target_min_reg - quot) : (target_min_reg + quot);
    end

    always_comb begin
        median_ext = mhpc_pkg::CMP_W'(median_latched_reg);
        target_ext = $signed({{(mhpc_pkg::CMP_W - mhpc_pkg::TGT_W){1'b0}},
                              acc_reg[mhpc_pkg::TGT_W-1:0]});
        hyst_ext   = $signed({{(mhpc_pkg::CMP_W - mhpc_pkg::HYST_W){1'b0}}, hysteresis_reg});
        band_lo    = target_ext - hyst_ext;
        band_hi    = target_ext + hyst_ext;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mhpc_pkg::ST_IDLE: begin
                if (s_accept && in_tick) begin
                    state_next = mhpc_pkg::ST_MUL_SPAN;
                end
            end
            mhpc_pkg::ST_MUL_SPAN: begin
                if (bit_cnt_reg == mhpc_pkg::BIT_CNT_W'(mhpc_pkg::POT_W - 1)) begin
                    state_next = mhpc_pkg::ST_SCALE;
                end
            end
            mhpc_pkg::ST_SCALE: begin
                state_next = mhpc_pkg::ST_MUL_PA;
            end
            mhpc_pkg::ST_MUL_PA: begin
                if (bit_cnt_reg == mhpc_pkg::BIT_CNT_W'(mhpc_pkg::CBAR_W - 1)) begin
                    state_next = mhpc_pkg::ST_COMPARE;
                end
            end
            mhpc_pkg::ST_COMPARE: begin
                state_next = mhpc_pkg::ST_OUT;
            end
            mhpc_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = mhpc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mhpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ready_int = (state_reg == mhpc_pkg::ST_IDLE) && !med_stat.busy;
        out_load  = (state_reg == mhpc_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= mhpc_pkg::ST_IDLE;
            offset_reg         <= mhpc_pkg::OFFSET_RST;
            target_min_reg     <= mhpc_pkg::TARGET_MIN_RST;
            target_max_reg     <= mhpc_pkg::TARGET_MAX_RST;
            hysteresis_reg     <= mhpc_pkg::HYSTERESIS_RST;
            low_batt_thr_reg   <= mhpc_pkg::LOW_BATT_RST;
            median_latched_reg <= '0;
            median_ready_reg   <= 1'b0;
            pump_reg           <= 1'b0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    mhpc_pkg::CFG_OFFSET:     offset_reg       <= cfg_data[mhpc_pkg::OFFSET_W-1:0];
                    mhpc_pkg::CFG_TARGET_MIN: target_min_reg   <= cfg_data[mhpc_pkg::CBAR_W-1:0];
                    mhpc_pkg::CFG_TARGET_MAX: target_max_reg   <= cfg_data[mhpc_pkg::CBAR_W-1:0];
                    mhpc_pkg::CFG_HYSTERESIS: hysteresis_reg   <= cfg_data[mhpc_pkg::HYST_W-1:0];
                    mhpc_pkg::CFG_LOW_BATT:   low_batt_thr_reg <= cfg_data[mhpc_pkg::BAT_W-1:0];
                    default: begin
                    end
                endcase
            end
            priority if (med_stat.done) begin
                median_latched_reg <= med_stat.median;
                median_ready_reg   <= 1'b1;
            end else if (state_reg == mhpc_pkg::ST_COMPARE && median_ready_reg) begin
                median_ready_reg <= 1'b0;
                priority if (median_ext < band_lo) begin
                    pump_reg <= 1'b1;
                end else if (median_ext > band_hi) begin
                    pump_reg <= 1'b0;
                end else begin
                    pump_reg <= pump_reg;
                end
            end else begin
                median_ready_reg <= median_ready_reg;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            mhpc_pkg::ST_IDLE: begin
                if (s_accept && in_tick) begin
                    span_neg_reg <= span_neg;
                    mcand_reg    <= mhpc_pkg::PROD_W'(span_mag);
                    sr_reg       <= in_pot;
                    acc_reg      <= '0;
                    bit_cnt_reg  <= '0;
                    bat_low_reg  <= (in_bat < low_batt_thr_reg);
                end
            end
            mhpc_pkg::ST_MUL_SPAN, mhpc_pkg::ST_MUL_PA: begin
                if (sr_reg[0]) begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg   <= {mcand_reg[mhpc_pkg::PROD_W-2:0], 1'b0};
                sr_reg      <= {1'b0, sr_reg[mhpc_pkg::POT_W-1:1]};
                bit_cnt_reg <= bit_cnt_reg + mhpc_pkg::BIT_CNT_W'(1);
            end
            mhpc_pkg::ST_SCALE: begin
                mcand_reg   <= mhpc_pkg::PA_PER_CBAR;
                sr_reg      <= mhpc_pkg::POT_W'(cbar);
                acc_reg     <= '0;
                bit_cnt_reg <= '0;
            end
            mhpc_pkg::ST_COMPARE: begin
                target_reg  <= acc_reg[mhpc_pkg::TGT_W-1:0];
                updated_reg <= median_ready_reg;
            end
            mhpc_pkg::ST_OUT: begin
                if (out_load) begin
                    m_tdata_reg <= {target_reg, median_latched_reg, updated_reg,
                                    bat_low_reg, pump_reg};
                end
            end
            default: begin
            end
        endcase
    end

    assign s_tready  = ready_int;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

endmodule

@@ rtl/core/mhpc_median.sv @@
// Sample block store and rank-counting upper median search.
`timescale 1ns / 1ps

module mhpc_median (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mhpc_pkg::med_cmd_t   cmd,
    output mhpc_pkg::med_stat_t  stat
);

    localparam logic [mhpc_pkg::IDX_W-1:0] LAST_IDX =
        mhpc_pkg::IDX_W'(mhpc_pkg::WINDOW_LEN - 1);
    localparam logic [mhpc_pkg::CNT_W-1:0] RANK_K =
        mhpc_pkg::CNT_W'(mhpc_pkg::MED_K);

    logic signed [mhpc_pkg::WIN_W-1:0] mem [mhpc_pkg::WINDOW_LEN];

    mhpc_pkg::med_state_t state_reg, state_next;

    logic [mhpc_pkg::IDX_W-1:0]        wr_pos_reg;
    logic [mhpc_pkg::IDX_W-1:0]        i_reg;
    logic [mhpc_pkg::IDX_W-1:0]        j_reg;
    logic signed [mhpc_pkg::WIN_W-1:0] rd_a_reg;
    logic signed [mhpc_pkg::WIN_W-1:0] rd_b_reg;
    logic                              vld_reg;
    logic                              last_j_reg;
    logic [mhpc_pkg::CNT_W-1:0]        less_reg;
    logic [mhpc_pkg::CNT_W-1:0]        leq_reg;
    logic signed [mhpc_pkg::WIN_W-1:0] median_reg;
    logic                              done_reg;

    logic                              scan_issue;
    logic                              busy;
    logic [mhpc_pkg::CNT_W-1:0]        less_sum;
    logic [mhpc_pkg::CNT_W-1:0]        leq_sum;
    logic                              found;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mhpc_pkg::MED_IDLE: begin
                if (cmd.push && wr_pos_reg == LAST_IDX) begin
                    state_next = mhpc_pkg::MED_SCAN;
                end
            end
            mhpc_pkg::MED_SCAN: begin
                if (i_reg == LAST_IDX && j_reg == LAST_IDX) begin
                    state_next = mhpc_pkg::MED_DRAIN;
                end
            end
            mhpc_pkg::MED_DRAIN: begin
                state_next = mhpc_pkg::MED_IDLE;
            end
            default: begin
                state_next = mhpc_pkg::MED_IDLE;
            end
        endcase
    end

    always_comb begin
        scan_issue = (state_reg == mhpc_pkg::MED_SCAN);
        busy       = (state_reg != mhpc_pkg::MED_IDLE);
    end

    always_comb begin
        less_sum = less_reg + mhpc_pkg::CNT_W'(rd_b_reg < rd_a_reg);
        leq_sum  = leq_reg + mhpc_pkg::CNT_W'(rd_b_reg <= rd_a_reg);
        found    = (less_sum <= RANK_K) && (leq_sum > RANK_K);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= mhpc_pkg::MED_IDLE;
            wr_pos_reg <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            vld_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            vld_reg   <= scan_issue;
            done_reg  <= (state_reg == mhpc_pkg::MED_DRAIN);
            if (cmd.push) begin
                wr_pos_reg <= (wr_pos_reg == LAST_IDX) ? '0
                                                       : wr_pos_reg + mhpc_pkg::IDX_W'(1);
            end
            if (scan_issue) begin
                if (j_reg == LAST_IDX) begin
                    j_reg <= '0;
                    i_reg <= i_reg + mhpc_pkg::IDX_W'(1);
                end else begin
                    j_reg <= j_reg + mhpc_pkg::IDX_W'(1);
                end
            end else begin
                i_reg <= '0;
                j_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[wr_pos_reg] <= cmd.value;
        end
        rd_a_reg   <= mem[i_reg];
        rd_b_reg   <= mem[j_reg];
        last_j_reg <= (j_reg == LAST_IDX);
    end

    always_ff @(posedge aclk) begin
        if (state_reg == mhpc_pkg::MED_IDLE) begin
            less_reg <= '0;
            leq_reg  <= '0;
        end else if (vld_reg) begin
            if (last_j_reg) begin
                less_reg <= '0;
                leq_reg  <= '0;
                if (found) begin
                    median_reg <= rd_a_reg;
                end
            end else begin
                less_reg <= less_sum;
                leq_reg  <= leq_sum;
            end
        end
    end

    assign stat.busy   = busy;
    assign stat.done   = done_reg;
    assign stat.median = median_reg;

endmodule

@@ rtl/core/mhpc_checker.sv @@
// Port-level checker for the pump control unit, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mhpc_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic [mhpc_pkg::IN_TDATA_W-1:0]       s_tdata,
    input logic [0:0]                            s_tuser,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [mhpc_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input logic                                  cfg_valid,
    input logic                                  cfg_ready,
    input logic [mhpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input logic [mhpc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic unused_ok;
    assign unused_ok = ^{s_tdata, cfg_valid, cfg_ready, cfg_index, cfg_data};

    `ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `ASSERT_RUN(a_tick_blocks_intake, aclk, aresetn, (s_tvalid && s_tready && s_tuser[0]) |=> !s_tready, "request taken during tick")
    `ASSERT_RUN(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")
    `ASSERT_RUN(a_target_range, aclk, aresetn, m_tvalid |-> (m_tdata[39:22] <= 18'd255000), "target out of range")

endmodule

bind median_hysteresis_pump_control_unit mhpc_checker u_mhpc_checker (.*);
